[rtl/vra_pkg.sv]
`timescale 1ns / 1ps
package vra_pkg;

  localparam int CoordW   = 32;
  localparam int AngW     = 18;
  localparam int MatFrac  = 24;
  localparam int UnitFrac = 30;
  localparam int CfgIdxW  = 3;

  typedef enum logic [1:0] {
    OP_ROT_X    = 2'd0,
    OP_ROT_Y    = 2'd1,
    OP_ROT_Z    = 2'd2,
    OP_ROT_AXIS = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5,
    REG_COS     = 3'd6,
    REG_SIN     = 3'd7
  } reg_idx_e;

  // composite transform handed from the setup unit to the vertex pipe
  typedef struct packed {
    logic [8:0][CoordW-1:0] m;
    logic [2:0][CoordW-1:0] o;
    logic                   zero_len;
  } comp_t;

endpackage

[rtl/vra_in_if.sv]
`timescale 1ns / 1ps
interface vra_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;

  modport source (output valid, op, in_x, in_y, in_z, input ready);
  modport sink   (input valid, op, in_x, in_y, in_z, output ready);
endinterface

[rtl/vra_out_if.sv]
`timescale 1ns / 1ps
interface vra_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               axis_invalid;
  logic               saturated;

  modport source (output valid, out_x, out_y, out_z, axis_invalid, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, axis_invalid, saturated, output ready);
endinterface

[rtl/vra_setup.sv]
`timescale 1ns / 1ps
module vra_setup import vra_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   restart_i,
  input  logic [2:0][CoordW-1:0] start_i,
  input  logic [2:0][CoordW-1:0] end_i,
  input  logic signed [AngW-1:0] cos_i,
  input  logic signed [AngW-1:0] sin_i,
  output logic [8:0][CoordW-1:0] mat_o,
  output logic                   zero_len_o,
  output logic                   busy_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LOAD  = 8'b0000_0010,
    ST_NORM  = 8'b0000_0100,
    ST_SQ    = 8'b0000_1000,
    ST_ROOT  = 8'b0001_0000,
    ST_DINIT = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_ENT   = 8'b1000_0000
  } st_e;

  st_e state_q;

  logic [32:0] mag0_q, mag1_q, mag2_q;
  logic        sgn0_q, sgn1_q, sgn2_q;
  logic [1:0]  cnt_q;
  logic [61:0] len2_q;
  logic [63:0] x_q, r_q;
  logic [4:0]  k_q;
  logic [60:0] num_q;
  logic [30:0] rem_q;
  logic [5:0]  dcnt_q;
  logic signed [31:0] u0_q, u1_q, u2_q;
  logic [1:0]  i_q, j_q, ph_q;
  logic [3:0]  eidx_q;
  logic signed [31:0] uu_q, cr_q;
  logic signed [49:0] p1_q;
  logic signed [50:0] p2_q;
  logic               diag_q;
  logic [8:0][CoordW-1:0] mat_q;
  logic                   zero_q;

  // load
  logic signed [32:0] d0, d1, d2;
  assign d0 = {end_i[0][31], end_i[0]} - {start_i[0][31], start_i[0]};
  assign d1 = {end_i[1][31], end_i[1]} - {start_i[1][31], start_i[1]};
  assign d2 = {end_i[2][31], end_i[2]} - {start_i[2][31], start_i[2]};

  // normalize
  logic [32:0] mx01, mx;
  assign mx01 = (mag1_q > mag0_q) ? mag1_q : mag0_q;
  assign mx   = (mag2_q > mx01) ? mag2_q : mx01;

  // square root step
  logic [63:0] b_val, rb;
  assign b_val = 64'd1 << {k_q, 1'b0};
  assign rb    = r_q + b_val;

  // division step
  logic [31:0] rem_sh;
  logic        ge;
  logic [30:0] quo;
  assign rem_sh = {rem_q, num_q[60]};
  assign ge     = rem_sh >= {1'b0, r_q[30:0]};
  assign quo    = {num_q[29:0], ge};

  // matrix entry terms
  logic signed [31:0] ua, ub, cr;
  logic signed [63:0] uprod, uround;
  logic signed [18:0] omc;
  logic signed [53:0] acc;

  always_comb begin
    case (i_q)
      2'd0:    ua = u0_q;
      2'd1:    ua = u1_q;
      default: ua = u2_q;
    endcase
    case (j_q)
      2'd0:    ub = u0_q;
      2'd1:    ub = u1_q;
      default: ub = u2_q;
    endcase
    case ({i_q, j_q})
      4'b00_01: cr = -u2_q;
      4'b00_10: cr = u1_q;
      4'b01_00: cr = u2_q;
      4'b01_10: cr = -u0_q;
      4'b10_00: cr = -u1_q;
      4'b10_01: cr = u0_q;
      default:  cr = '0;
    endcase
  end

  assign uprod  = ua * ub;
  assign uround = uprod + (64'sd1 <<< (UnitFrac - 1));
  assign omc    = 19'sd65536 - 19'(cos_i);
  assign acc    = 54'(p1_q) + 54'(p2_q)
                + (diag_q ? (54'(cos_i) <<< UnitFrac) : 54'sd0)
                + (54'sd1 <<< (16 + UnitFrac - MatFrac - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      zero_q  <= 1'b1;
      for (int e = 0; e < 9; e++) begin
        mat_q[e] <= (e % 4 == 0) ? (32'd1 << MatFrac) : 32'd0;
      end
    end else if (restart_i) begin
      state_q <= ST_LOAD;
    end else begin
      case (state_q)
        ST_IDLE: state_q <= ST_IDLE;
        ST_LOAD: begin
          sgn0_q <= d0[32];
          sgn1_q <= d1[32];
          sgn2_q <= d2[32];
          mag0_q <= d0[32] ? 33'(-d0) : 33'(d0);
          mag1_q <= d1[32] ? 33'(-d1) : 33'(d1);
          mag2_q <= d2[32] ? 33'(-d2) : 33'(d2);
          if (d0 == '0 && d1 == '0 && d2 == '0) begin
            zero_q <= 1'b1;
            for (int e = 0; e < 9; e++) begin
              mat_q[e] <= (e % 4 == 0) ? (32'd1 << MatFrac) : 32'd0;
            end
            state_q <= ST_IDLE;
          end else begin
            zero_q  <= 1'b0;
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (mx[32:30] != 3'd0) begin
            mag0_q <= mag0_q >> 1;
            mag1_q <= mag1_q >> 1;
            mag2_q <= mag2_q >> 1;
          end else if (mx[32:29] == 4'd0) begin
            mag0_q <= mag0_q << 1;
            mag1_q <= mag1_q << 1;
            mag2_q <= mag2_q << 1;
          end else begin
            len2_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          // square the head magnitude, rotate the three
          len2_q <= len2_q + 62'(mag0_q[29:0] * mag0_q[29:0]);
          mag0_q <= mag1_q;
          mag1_q <= mag2_q;
          mag2_q <= mag0_q;
          cnt_q  <= cnt_q + 2'd1;
          if (cnt_q == 2'd2) begin
            x_q     <= 64'(len2_q + 62'(mag0_q[29:0] * mag0_q[29:0]));
            r_q     <= '0;
            k_q     <= 5'd31;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (x_q >= rb) begin
            x_q <= x_q - rb;
            r_q <= (r_q >> 1) + b_val;
          end else begin
            r_q <= r_q >> 1;
          end
          k_q <= k_q - 5'd1;
          if (k_q == 5'd0) begin
            cnt_q   <= '0;
            state_q <= ST_DINIT;
          end
        end
        ST_DINIT: begin
          // numerator rounds the quotient to nearest
          num_q   <= {1'b0, mag0_q[29:0], 30'd0} + 61'(r_q[30:1]);
          rem_q   <= '0;
          dcnt_q  <= 6'd60;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= ge ? 31'(rem_sh - {1'b0, r_q[30:0]}) : rem_sh[30:0];
          num_q  <= {num_q[59:0], ge};
          dcnt_q <= dcnt_q - 6'd1;
          if (dcnt_q == 6'd0) begin
            u2_q   <= sgn0_q ? (32'sd0 - $signed({1'b0, quo})) : $signed({1'b0, quo});
            u1_q   <= u2_q;
            u0_q   <= u1_q;
            mag0_q <= mag1_q;
            mag1_q <= mag2_q;
            mag2_q <= mag0_q;
            sgn0_q <= sgn1_q;
            sgn1_q <= sgn2_q;
            sgn2_q <= sgn0_q;
            cnt_q  <= cnt_q + 2'd1;
            if (cnt_q == 2'd2) begin
              i_q     <= '0;
              j_q     <= '0;
              ph_q    <= '0;
              eidx_q  <= '0;
              state_q <= ST_ENT;
            end else begin
              state_q <= ST_DINIT;
            end
          end
        end
        ST_ENT: begin
          case (ph_q)
            2'd0: begin
              uu_q <= uround[61:30];
              cr_q <= cr;
              ph_q <= 2'd1;
            end
            2'd1: begin
              p1_q   <= sin_i * cr_q;
              p2_q   <= omc * uu_q;
              diag_q <= (i_q == j_q);
              ph_q   <= 2'd2;
            end
            default: begin
              mat_q[eidx_q] <= acc[53:22];
              ph_q          <= 2'd0;
              eidx_q        <= eidx_q + 4'd1;
              if (j_q == 2'd2) begin
                j_q <= 2'd0;
                i_q <= i_q + 2'd1;
              end else begin
                j_q <= j_q + 2'd1;
              end
              if (eidx_q == 4'd8) begin
                state_q <= ST_IDLE;
              end
            end
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign mat_o      = mat_q;
  assign zero_len_o = zero_q;
  assign busy_o     = (state_q != ST_IDLE);

endmodule

[rtl/vra_pipe.sv]
`timescale 1ns / 1ps
module vra_pipe import vra_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [1:0]             op_i,
  input  logic signed [31:0]     x_i,
  input  logic signed [31:0]     y_i,
  input  logic signed [31:0]     z_i,
  input  logic signed [AngW-1:0] cos_i,
  input  logic signed [AngW-1:0] sin_i,
  input  comp_t                  comp_i,
  output logic                   valid_o,
  output logic signed [31:0]     x_o,
  output logic signed [31:0]     y_o,
  output logic signed [31:0]     z_o,
  output logic                   invalid_o,
  output logic                   sat_o
);

  logic signed [31:0] c24, s24, one24;
  assign c24   = 32'(cos_i) <<< 8;
  assign s24   = 32'(sin_i) <<< 8;
  assign one24 = 32'sd1 <<< MatFrac;

  // stage 1: matrix select, subtract offset
  logic signed [31:0] msel [9];
  logic signed [31:0] osel [3];
  logic signed [31:0] vin  [3];
  logic               axis_sel;

  assign vin[0]   = x_i;
  assign vin[1]   = y_i;
  assign vin[2]   = z_i;
  assign axis_sel = (op_e'(op_i) == OP_ROT_AXIS);

  always_comb begin
    for (int e = 0; e < 9; e++) msel[e] = '0;
    for (int k = 0; k < 3; k++) osel[k] = '0;
    case (op_e'(op_i))
      OP_ROT_X: begin
        msel[0] = one24; msel[4] = c24; msel[5] = -s24; msel[7] = s24; msel[8] = c24;
      end
      OP_ROT_Y: begin
        msel[0] = c24; msel[2] = s24; msel[4] = one24; msel[6] = -s24; msel[8] = c24;
      end
      OP_ROT_Z: begin
        msel[0] = c24; msel[1] = -s24; msel[3] = s24; msel[4] = c24; msel[8] = one24;
      end
      default: begin
        for (int e = 0; e < 9; e++) msel[e] = $signed(comp_i.m[e]);
        for (int k = 0; k < 3; k++) osel[k] = $signed(comp_i.o[k]);
      end
    endcase
  end

  logic               v1_q, inv1_q;
  logic signed [31:0] m1_q [9];
  logic signed [32:0] d1_q [3];
  logic signed [31:0] o1_q [3];

  // stage 2: products
  logic               v2_q, inv2_q;
  logic signed [64:0] p2_q [9];
  logic signed [31:0] o2_q [3];

  // stage 3: row sums
  logic               v3_q, inv3_q;
  logic signed [67:0] a3_q [3];
  logic signed [67:0] a3_d [3];

  // stage 4: round and clip
  logic signed [43:0] r4   [3];
  logic signed [31:0] c4   [3];
  logic [2:0]         hit4;
  logic               v4_q, inv4_q, sat4_q;
  logic signed [31:0] q4_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a3_d[i] = (68'(o2_q[i]) <<< MatFrac) + (68'sd1 <<< (MatFrac - 1))
              + 68'(p2_q[3*i]) + 68'(p2_q[3*i+1]) + 68'(p2_q[3*i+2]);
      r4[i]   = a3_q[i][67:24];
      hit4[i] = 1'b0;
      c4[i]   = r4[i][31:0];
      if (r4[i] > 44'sd2147483647) begin
        c4[i] = 32'sh7fffffff; hit4[i] = 1'b1;
      end else if (r4[i] < -44'sd2147483648) begin
        c4[i] = 32'sh80000000; hit4[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // a zero-length axis holds identity about the start point: exact pass
      inv1_q <= axis_sel & comp_i.zero_len;
      for (int e = 0; e < 9; e++) m1_q[e] <= msel[e];
      for (int k = 0; k < 3; k++) begin
        d1_q[k] <= 33'(vin[k]) - 33'(osel[k]);
        o1_q[k] <= osel[k];
      end
      inv2_q <= inv1_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) p2_q[3*i+j] <= m1_q[3*i+j] * d1_q[j];
        o2_q[i] <= o1_q[i];
      end
      inv3_q <= inv2_q;
      for (int i = 0; i < 3; i++) a3_q[i] <= a3_d[i];
      inv4_q <= inv3_q;
      sat4_q <= |hit4;
      for (int i = 0; i < 3; i++) q4_q[i] <= c4[i];
    end
  end

  assign valid_o   = v4_q;
  assign x_o       = q4_q[0];
  assign y_o       = q4_q[1];
  assign z_o       = q4_q[2];
  assign invalid_o = inv4_q;
  assign sat_o     = sat4_q;

endmodule

[rtl/vertex_rotate_about_axis.sv]
`timescale 1ns / 1ps
// Rotates one Q16.16 vertex per transaction about x, y, z or a configured axis.
// vtx_i (sink) takes op and the vertex; vtx_o (source) returns the rotated,
// saturated vertex plus axis_invalid and saturated flags.
// Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i. Write
// them only while no transaction is in flight; the block does not enforce it.
// Four pipeline stages: matrix select, products, row sums, round and clip.
// Throughput: one vertex per cycle unless stalled or the setup unit is busy.
// After any register write the setup unit rebuilds the composite axis matrix
// (normalize shift loop, 32-step square root, three 61-step divisions, nine
// matrix entries of load, product and accumulate phases); during the rebuild
// vtx_i.ready is low. A zero-length axis stops at load with an identity matrix.
// Reset: registers return to zero axis points and a 20 degree angle; the
// composite is identity and the axis is flagged invalid.
// When the receiver stalls, the whole pipeline holds and vtx_i.ready drops;
// nothing is lost or repeated.
module vertex_rotate_about_axis import vra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  vra_in_if.sink             vtx_i,
  vra_out_if.source          vtx_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);

  logic [2:0][CoordW-1:0] start_q, end_q;
  logic signed [AngW-1:0] cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      cos_q   <= 18'sd61583;
      sin_q   <= 18'sd22415;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_START_X: start_q[0] <= cfg_wdata_i;
        REG_START_Y: start_q[1] <= cfg_wdata_i;
        REG_START_Z: start_q[2] <= cfg_wdata_i;
        REG_END_X:   end_q[0]   <= cfg_wdata_i;
        REG_END_Y:   end_q[1]   <= cfg_wdata_i;
        REG_END_Z:   end_q[2]   <= cfg_wdata_i;
        REG_COS:     cos_q      <= cfg_wdata_i[AngW-1:0];
        REG_SIN:     sin_q      <= cfg_wdata_i[AngW-1:0];
        default:     cos_q      <= cos_q;
      endcase
    end
  end

  logic [8:0][CoordW-1:0] mat;
  logic                   zero_len, busy, en, pipe_valid;
  comp_t                  comp;

  vra_setup u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_we_i),
    .start_i    (start_q),
    .end_i      (end_q),
    .cos_i      (cos_q),
    .sin_i      (sin_q),
    .mat_o      (mat),
    .zero_len_o (zero_len),
    .busy_o     (busy)
  );

  assign comp.m        = mat;
  assign comp.o        = start_q;
  assign comp.zero_len = zero_len;

  assign en          = !pipe_valid || vtx_o.ready;
  assign vtx_i.ready = en && !busy;

  vra_pipe u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (vtx_i.valid && !busy),
    .op_i      (vtx_i.op),
    .x_i       (vtx_i.in_x),
    .y_i       (vtx_i.in_y),
    .z_i       (vtx_i.in_z),
    .cos_i     (cos_q),
    .sin_i     (sin_q),
    .comp_i    (comp),
    .valid_o   (pipe_valid),
    .x_o       (vtx_o.out_x),
    .y_o       (vtx_o.out_y),
    .z_o       (vtx_o.out_z),
    .invalid_o (vtx_o.axis_invalid),
    .sat_o     (vtx_o.saturated)
  );

  assign vtx_o.valid = pipe_valid;

endmodule
